// ===== rtl/core/tcgr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types and constants for the text console glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  localparam int GLYPH_WIDTH       = 8;
  localparam int GLYPH_HEIGHT_DEF  = 16;
  localparam int GLYPH_COUNT_DEF   = 256;
  localparam int COORD_BITS        = 12;
  localparam int TAB_CELLS         = 4;

  localparam int CODE_W      = 8;
  localparam int FONT_ADDR_W = 12;
  localparam int BITS_W      = 8;
  localparam int CFG_W       = 12;
  localparam int COLOR_W     = 32;
  localparam int PIX_W       = 12;
  localparam int SCROLL_W    = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

  localparam logic [CODE_W-1:0] CHAR_NL    = 8'd10;
  localparam logic [CODE_W-1:0] CHAR_BS    = 8'd8;
  localparam logic [CODE_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CODE_W-1:0] CHAR_SPACE = 8'd32;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_START_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR      = 3'd4;

  localparam logic [CFG_W-1:0]   SCREEN_WIDTH_RST  = 12'd1024;
  localparam logic [CFG_W-1:0]   SCREEN_HEIGHT_RST = 12'd768;
  localparam logic [CFG_W-1:0]   LINE_START_X_RST  = 12'd0;
  localparam logic [COLOR_W-1:0] FG_COLOR_RST      = 32'h00FF_FFFF;
  localparam logic [COLOR_W-1:0] BG_COLOR_RST      = 32'h0000_0000;

  localparam logic ALU_ADD_SAT   = 1'b0;
  localparam logic ALU_SUB_CLAMP = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [CODE_W-1:0]       char_code;
    logic [FONT_ADDR_W-1:0]  font_addr;
    logic [BITS_W-1:0]       font_bits;
  } in_item_t;

  typedef struct packed {
    logic                    kind;
    logic [PIX_W-1:0]        pixel_x;
    logic [PIX_W-1:0]        pixel_y;
    logic [BITS_W-1:0]       row_bits;
    logic [COLOR_W-1:0]      row_fg;
    logic [COLOR_W-1:0]      row_bg;
    logic [SCROLL_W-1:0]     scroll_pixels;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic                    op;
    logic [COORD_BITS-1:0]   a;
    logic [COORD_BITS-1:0]   b;
    logic [CFG_W-1:0]        lim;
  } alu_req_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]   value;
    logic                    gt;
    logic                    ge;
  } alu_res_t;

endpackage

// ===== rtl/core/tcgr_alu.sv =====
// ----------------------------------------------------------------------------
// tcgr_alu
// Shared coordinate unit: saturating add or clamped subtract, plus a compare
// of the exact sum against a screen limit.
// ----------------------------------------------------------------------------
module tcgr_alu
  import tcgr_pkg::*;
(
  input  alu_req_t req,
  output alu_res_t res
);

  logic [COORD_BITS:0] sum;

  always_comb begin
    sum      = {1'b0, req.a} + {1'b0, req.b};
    res.gt   = sum >  (COORD_BITS + 1)'(req.lim);
    res.ge   = sum >= (COORD_BITS + 1)'(req.lim);
    if (req.op == ALU_SUB_CLAMP) begin
      res.value = (req.a >= req.b) ? (req.a - req.b) : '0;
    end else begin
      res.value = sum[COORD_BITS] ? COORD_MAX : sum[COORD_BITS-1:0];
    end
  end

endmodule

// ===== rtl/core/tcgr_font_mem.sv =====
// ----------------------------------------------------------------------------
// tcgr_font_mem
// Font row store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tcgr_font_mem
  import tcgr_pkg::*;
#(
  parameter int DEPTH = GLYPH_COUNT_DEF * GLYPH_HEIGHT_DEF,
  parameter int AW    = $clog2(DEPTH)
)(
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BITS_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [BITS_W-1:0] rdata
);

  logic [BITS_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/tcgr_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcgr_ctrl
// Sequencer: cursor state, font store access, row pipeline and result
// register. Cursor arithmetic goes through the shared coordinate unit.
// ----------------------------------------------------------------------------
module tcgr_ctrl
  import tcgr_pkg::*;
#(
  parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF,
  parameter int GLYPH_COUNT  = GLYPH_COUNT_DEF,
  parameter int DEPTH        = GLYPH_COUNT * GLYPH_HEIGHT,
  parameter int SAW          = $clog2(DEPTH)
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic [CFG_W-1:0]   screen_width,
  input  logic [CFG_W-1:0]   screen_height,
  input  logic [CFG_W-1:0]   line_start_x,
  input  logic [COLOR_W-1:0] fg_color,
  input  logic [COLOR_W-1:0] bg_color,
  output logic               mem_we,
  output logic [SAW-1:0]     mem_waddr,
  output logic [BITS_W-1:0]  mem_wdata,
  output logic               mem_re,
  output logic [SAW-1:0]     mem_raddr,
  input  logic [BITS_W-1:0]  mem_rdata,
  output alu_req_t           alu_req,
  input  alu_res_t           alu_res
);

  localparam int RW     = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
  localparam int EXT_W  = ((SAW > FONT_ADDR_W) ? SAW : FONT_ADDR_W) + 1;
  localparam int CCMP_W = CODE_W + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WRAP   = 3'd1;
  localparam logic [2:0] S_WRAPY  = 3'd2;
  localparam logic [2:0] S_EMIT   = 3'd3;
  localparam logic [2:0] S_ADVX   = 3'd4;
  localparam logic [2:0] S_NL     = 3'd5;
  localparam logic [2:0] S_NLDOWN = 3'd6;
  localparam logic [2:0] S_SCROLL = 3'd7;

  logic [2:0]            state_r, state_nxt;
  logic [CODE_W-1:0]     code_r, code_nxt;
  logic [COORD_BITS-1:0] cursor_x_r, cursor_x_nxt;
  logic [COORD_BITS-1:0] cursor_y_r, cursor_y_nxt;
  logic [COORD_BITS-1:0] rowy_r, rowy_nxt;
  logic [RW-1:0]         row_r, row_nxt;
  logic [SAW-1:0]        raddr_r, raddr_nxt;
  logic                  blank_r, blank_nxt;

  logic                  p1_valid_r, p1_valid_nxt;
  logic                  p1_kind_r, p1_kind_nxt;
  logic [COORD_BITS-1:0] p1_x_r, p1_x_nxt;
  logic [COORD_BITS-1:0] p1_y_r, p1_y_nxt;
  logic                  p1_blank_r, p1_blank_nxt;
  logic                  p1_last_r, p1_last_nxt;

  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  acc;
  logic                  p1_move;
  logic                  p1_free;
  logic                  push;
  logic                  row_last;
  logic [CODE_W-1:0]     sel_code;
  logic [EXT_W-1:0]      waddr_ext;
  logic [COORD_BITS-1:0] start_x;

  assign in_ready  = (state_r == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign p1_move   = p1_valid_r && (!out_valid_r || out_ready);
  assign p1_free   = !p1_valid_r || p1_move;
  assign push      = ((state_r == S_EMIT) || (state_r == S_SCROLL)) && p1_free;
  assign row_last  = (row_r == RW'(GLYPH_HEIGHT - 1));
  assign sel_code  = (in_data.char_code == CHAR_BS) ? CHAR_SPACE : in_data.char_code;
  assign waddr_ext = EXT_W'(in_data.font_addr);
  assign start_x   = COORD_BITS'(line_start_x);

  assign mem_we    = acc && in_data.req_type && (waddr_ext < EXT_W'(DEPTH));
  assign mem_waddr = waddr_ext[SAW-1:0];
  assign mem_wdata = in_data.font_bits;
  assign mem_re    = (state_r == S_EMIT) && p1_free && !blank_r;
  assign mem_raddr = raddr_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    alu_req.op  = ALU_ADD_SAT;
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.lim = '0;
    case (state_r)
      S_WRAP: begin
        alu_req.a   = cursor_x_r;
        alu_req.b   = COORD_BITS'(GLYPH_WIDTH);
        alu_req.lim = screen_width;
      end
      S_WRAPY, S_NLDOWN: begin
        alu_req.a = cursor_y_r;
        alu_req.b = COORD_BITS'(GLYPH_HEIGHT);
      end
      S_NL: begin
        alu_req.a   = cursor_y_r;
        alu_req.b   = COORD_BITS'(2 * GLYPH_HEIGHT);
        alu_req.lim = screen_height;
      end
      S_SCROLL: begin
        alu_req.op = ALU_SUB_CLAMP;
        alu_req.a  = cursor_y_r;
        alu_req.b  = COORD_BITS'(GLYPH_HEIGHT);
      end
      S_EMIT: begin
        alu_req.a = rowy_r;
        alu_req.b = COORD_BITS'(1);
      end
      S_ADVX: begin
        alu_req.a = cursor_x_r;
        if (code_r == CHAR_BS) begin
          alu_req.op = ALU_SUB_CLAMP;
          alu_req.b  = COORD_BITS'(GLYPH_WIDTH);
        end else if (code_r == CHAR_TAB) begin
          alu_req.b = COORD_BITS'(TAB_CELLS * GLYPH_WIDTH);
        end else begin
          alu_req.b = COORD_BITS'(GLYPH_WIDTH);
        end
      end
      default: begin
        alu_req.op = ALU_ADD_SAT;
      end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    code_nxt     = code_r;
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    rowy_nxt     = rowy_r;
    row_nxt      = row_r;
    raddr_nxt    = raddr_r;
    blank_nxt    = blank_r;
    case (state_r)
      S_IDLE: begin
        if (acc && !in_data.req_type) begin
          code_nxt  = in_data.char_code;
          row_nxt   = '0;
          blank_nxt = !({1'b0, sel_code} < CCMP_W'(GLYPH_COUNT));
          raddr_nxt = SAW'(32'(sel_code) * GLYPH_HEIGHT);
          if (in_data.char_code == CHAR_NL) begin
            state_nxt = S_NL;
          end else if (in_data.char_code == CHAR_TAB) begin
            state_nxt = S_ADVX;
          end else begin
            state_nxt = S_WRAP;
          end
        end
      end
      S_WRAP: begin
        if (alu_res.gt) begin
          state_nxt = S_WRAPY;
        end else begin
          rowy_nxt  = cursor_y_r;
          state_nxt = S_EMIT;
        end
      end
      S_WRAPY: begin
        cursor_x_nxt = start_x;
        cursor_y_nxt = alu_res.value;
        rowy_nxt     = alu_res.value;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (push) begin
          rowy_nxt  = alu_res.value;
          raddr_nxt = raddr_r + SAW'(1);
          if (row_last) begin
            row_nxt   = '0;
            state_nxt = S_ADVX;
          end else begin
            row_nxt = row_r + RW'(1);
          end
        end
      end
      S_ADVX: begin
        cursor_x_nxt = alu_res.value;
        state_nxt    = S_IDLE;
      end
      S_NL: begin
        state_nxt = alu_res.ge ? S_SCROLL : S_NLDOWN;
      end
      S_NLDOWN: begin
        cursor_x_nxt = start_x;
        cursor_y_nxt = alu_res.value;
        state_nxt    = S_IDLE;
      end
      S_SCROLL: begin
        if (push) begin
          cursor_x_nxt = start_x;
          cursor_y_nxt = alu_res.value;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // row pipeline: font read stage, then result register
  always_comb begin
    p1_valid_nxt = p1_valid_r;
    p1_kind_nxt  = p1_kind_r;
    p1_x_nxt     = p1_x_r;
    p1_y_nxt     = p1_y_r;
    p1_blank_nxt = p1_blank_r;
    p1_last_nxt  = p1_last_r;
    if (push) begin
      p1_valid_nxt = 1'b1;
      p1_kind_nxt  = (state_r == S_SCROLL);
      p1_x_nxt     = cursor_x_r;
      p1_y_nxt     = rowy_r;
      p1_blank_nxt = blank_r || (state_r == S_SCROLL);
      p1_last_nxt  = row_last || (state_r == S_SCROLL);
    end else if (p1_move) begin
      p1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (p1_move) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.kind          = p1_kind_r;
      out_data_nxt.pixel_x       = p1_kind_r ? '0 : PIX_W'(p1_x_r);
      out_data_nxt.pixel_y       = p1_kind_r ? '0 : PIX_W'(p1_y_r);
      out_data_nxt.row_bits      = p1_blank_r ? '0 : mem_rdata;
      out_data_nxt.row_fg        = p1_kind_r ? '0 : fg_color;
      out_data_nxt.row_bg        = p1_kind_r ? '0 : bg_color;
      out_data_nxt.scroll_pixels = p1_kind_r ? SCROLL_W'(2 * GLYPH_HEIGHT) : '0;
      out_data_nxt.last          = p1_last_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      row_r       <= '0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_x_r  <= cursor_x_nxt;
      cursor_y_r  <= cursor_y_nxt;
      row_r       <= row_nxt;
      p1_valid_r  <= p1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r     <= code_nxt;
    rowy_r     <= rowy_nxt;
    raddr_r    <= raddr_nxt;
    blank_r    <= blank_nxt;
    p1_kind_r  <= p1_kind_nxt;
    p1_x_r     <= p1_x_nxt;
    p1_y_r     <= p1_y_nxt;
    p1_blank_r <= p1_blank_nxt;
    p1_last_r  <= p1_last_nxt;
    out_data_r <= out_data_nxt;
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!p1_valid_r || p1_move))
    else $error("row pushed into occupied read stage");

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && push && row_last) |=> (state_r == S_ADVX))
    else $error("sequencer missed end of glyph");

  a_idle_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (row_r == '0))
    else $error("row counter not rewound at idle");

  a_read_emit: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> (state_r == S_EMIT && !blank_r))
    else $error("font read outside glyph emission");

endmodule

// ===== rtl/core/text_console_glyph_renderer_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_unit
// Pixel-mode text console: font store loads, cursor tracking and emission
// of glyph rows and scroll requests.
// ----------------------------------------------------------------------------
// Font load: the row is written on acceptance. Tab: a cursor step. Newline:
// a limit check, then a cursor move down or a scroll request.
// Printable or backspace: a wrap check (and a wrap to the next line if needed),
// then one glyph row per cycle from the font store read port while the output
// is not stalled, then a cursor step. A new item is taken only once the last is done.
// Synchronous active-low reset clears the cursor, the registers to their defaults
// and the pipeline; the font store is not cleared.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_unit
  import tcgr_pkg::*;
#(
  parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF,
  parameter int GLYPH_COUNT  = GLYPH_COUNT_DEF
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int SAW   = $clog2(DEPTH);

  logic [CFG_W-1:0]   screen_width_r;
  logic [CFG_W-1:0]   screen_height_r;
  logic [CFG_W-1:0]   line_start_x_r;
  logic [COLOR_W-1:0] fg_color_r;
  logic [COLOR_W-1:0] bg_color_r;

  logic               mem_we;
  logic [SAW-1:0]     mem_waddr;
  logic [BITS_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [SAW-1:0]     mem_raddr;
  logic [BITS_W-1:0]  mem_rdata;
  alu_req_t           alu_req;
  alu_res_t           alu_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
      line_start_x_r  <= LINE_START_X_RST;
      fg_color_r      <= FG_COLOR_RST;
      bg_color_r      <= BG_COLOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata[CFG_W-1:0];
        REG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata[CFG_W-1:0];
        REG_LINE_START_X:  line_start_x_r  <= cfg_wdata[CFG_W-1:0];
        REG_FG_COLOR:      fg_color_r      <= cfg_wdata[COLOR_W-1:0];
        REG_BG_COLOR:      bg_color_r      <= cfg_wdata[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tcgr_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  tcgr_font_mem #(
    .DEPTH (DEPTH),
    .AW    (SAW)
  ) u_font_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tcgr_ctrl #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .GLYPH_COUNT  (GLYPH_COUNT),
    .DEPTH        (DEPTH),
    .SAW          (SAW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .screen_width  (screen_width_r),
    .screen_height (screen_height_r),
    .line_start_x  (line_start_x_r),
    .fg_color      (fg_color_r),
    .bg_color      (bg_color_r),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .alu_req       (alu_req),
    .alu_res       (alu_res)
  );

endmodule
